// File: rtl/usm_pkg.sv
package usm_pkg;

	// fixed field widths
	localparam int PIX_W = 16;
	localparam int POS_W = 11;
	localparam int SPOS_W = 13;
	localparam int ACC_W = 36;
	localparam int PROD_W = 32;
	localparam int NTAP = 9;
	localparam int TAP_W = 4;
	localparam int NCOEF = 5;

	// register indexes
	localparam logic [2:0] REG_COEF_CENTER = 3'd0;
	localparam logic [2:0] REG_COEF_ONE = 3'd1;
	localparam logic [2:0] REG_COEF_TWO = 3'd2;
	localparam logic [2:0] REG_COEF_THREE = 3'd3;
	localparam logic [2:0] REG_COEF_FOUR = 3'd4;
	localparam logic [2:0] REG_FRAME_WIDTH = 3'd5;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd6;

	// register reset values
	localparam logic [15:0] RST_COEF_CENTER = 16'd17468;
	localparam logic [15:0] RST_COEF_ONE = 16'd13989;
	localparam logic [15:0] RST_COEF_TWO = 16'd7182;
	localparam logic [15:0] RST_COEF_THREE = 16'd2364;
	localparam logic [15:0] RST_COEF_FOUR = 16'd499;
	localparam logic [10:0] RST_FRAME_WIDTH = 11'd1920;
	localparam logic [10:0] RST_FRAME_HEIGHT = 11'd1080;

	typedef logic [NCOEF-1:0][PIX_W-1:0] coef_arr_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_WR,
		ST_ADV,
		ST_PIX,
		ST_COL,
		ST_RD,
		ST_MUL,
		ST_ACC,
		ST_VRND,
		ST_HMUL,
		ST_HACC,
		ST_FIN,
		ST_OUT,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mod;
		logic wr;
		logic adv;
		logic pix_init;
		logic col_init;
		logic rd;
		logic mul;
		logic vacc;
		logic vrnd;
		logic hmul;
		logic hacc;
		logic fin;
		logic emit;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic has_out;
		logic j_last;
		logic k_last;
		logic pix_last;
	} sts_t;

	// row mod 9 by reciprocal multiply; exact for any 11-bit row
	function automatic logic [3:0] mod9(input logic [POS_W-1:0] v);
		logic [23:0] prod;
		logic [POS_W-1:0] q;
		logic [POS_W-1:0] rem;
		prod = 24'(v) * 24'd7282;
		q = prod[16 +: POS_W];
		rem = v - POS_W'(q * POS_W'(9));
		return rem[3:0];
	endfunction

	// round half up, drop 16 fraction bits, saturate
	function automatic logic [PIX_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
		logic [ACC_W:0] s;
		s = {1'b0, acc} + (ACC_W+1)'(32768);
		if (s[ACC_W:32] != '0)
			return '1;
		return s[31:16];
	endfunction

	// weight of a tap by its distance from the center
	function automatic logic [PIX_W-1:0] tap_weight(input coef_arr_t c, input logic [TAP_W-1:0] t);
		logic [TAP_W-1:0] d;
		d = (t < TAP_W'(4)) ? TAP_W'(4) - t : t - TAP_W'(4);
		return c[d[2:0]];
	endfunction

endpackage

// File: rtl/usm_ctrl.sv
module usm_ctrl
	import usm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   out_stall,
	input  sts_t   sts,
	output logic   in_stall,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.mod = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				cmd.wr = 1'b1;
				state_d = sts.has_out ? ST_PIX : ST_ADV;
			end
			ST_ADV: begin
				cmd.adv = 1'b1;
				state_d = ST_IDLE;
			end
			ST_PIX: begin
				cmd.pix_init = 1'b1;
				state_d = ST_COL;
			end
			ST_COL: begin
				cmd.col_init = 1'b1;
				state_d = ST_RD;
			end
			ST_RD: begin
				cmd.rd = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.vacc = 1'b1;
				state_d = sts.j_last ? ST_VRND : ST_RD;
			end
			ST_VRND: begin
				cmd.vrnd = 1'b1;
				state_d = ST_HMUL;
			end
			ST_HMUL: begin
				cmd.hmul = 1'b1;
				state_d = ST_HACC;
			end
			ST_HACC: begin
				cmd.hacc = 1'b1;
				state_d = sts.k_last ? ST_FIN : ST_COL;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				cmd.emit = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (!out_stall) begin
					cmd.step = 1'b1;
					state_d = sts.pix_last ? ST_ADV : ST_PIX;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/usm_dp.sv
module usm_dp
	import usm_pkg::*;
#(
	parameter int MAX_WIDTH = 1920,
	parameter int MAX_HEIGHT = 1080
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  coef_arr_t         coef,
	input  logic [POS_W-1:0]  frame_width,
	input  logic [POS_W-1:0]  frame_height,
	input  logic [PIX_W-1:0]  pixel_in,
	output logic              out_valid,
	output logic [PIX_W-1:0]  pixel_out,
	output logic [POS_W-1:0]  out_col,
	output logic [POS_W-1:0]  out_row,
	output logic              run_last
);

	localparam int DEPTH = NTAP * MAX_WIDTH;
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
	localparam logic [SPOS_W-1:0] MW_S = SPOS_W'(MAX_WIDTH);
	localparam logic [SPOS_W-1:0] MH_S = SPOS_W'(MAX_HEIGHT);

	logic [PIX_W-1:0] mem [DEPTH];

	logic [POS_W-1:0] col_count_q, row_count_q;
	logic [PIX_W-1:0] pix_q;
	logic [POS_W-1:0] c_q, r_q;
	logic [3:0] rs_q;
	logic [POS_W-1:0] x_q, y_q, x0_q, x1_q, y1_q;
	logic [TAP_W-1:0] j_q, k_q;
	logic signed [SPOS_W-1:0] xpos_q, ypos_q;
	logic [ACC_W-1:0] vacc_q, hacc_q;
	logic [PROD_W-1:0] prod_s1;
	logic [PIX_W-1:0] vr_q, blur_q, rdata_q;
	logic out_valid_q;
	logic [PIX_W-1:0] pixel_out_q;
	logic [POS_W-1:0] out_col_q, out_row_q;
	logic run_last_q;

	// effective frame size
	logic [SPOS_W-1:0] w_s, h_s;
	logic [POS_W-1:0] w_m1, h_m1;
	always_comb begin
		w_s = SPOS_W'(frame_width);
		h_s = SPOS_W'(frame_height);
		if (w_s < SPOS_W'(NTAP))
			w_s = SPOS_W'(NTAP);
		else if (w_s > MW_S)
			w_s = MW_S;
		if (h_s < SPOS_W'(NTAP))
			h_s = SPOS_W'(NTAP);
		else if (h_s > MH_S)
			h_s = MH_S;
		w_m1 = POS_W'(w_s - SPOS_W'(1));
		h_m1 = POS_W'(h_s - SPOS_W'(1));
	end

	// output window for the current pixel
	logic x_ok, y_ok;
	logic [POS_W-1:0] x0_d, x1_d, y0_d, y1_d;
	always_comb begin
		x_ok = 1'b1;
		y_ok = 1'b1;
		x0_d = c_q - POS_W'(4);
		x1_d = c_q;
		y0_d = r_q - POS_W'(4);
		y1_d = r_q;
		priority if (c_q == w_m1) begin
			x1_d = c_q;
		end else if (c_q >= POS_W'(4)) begin
			x1_d = x0_d;
		end else begin
			x_ok = 1'b0;
		end
		priority if (r_q == h_m1) begin
			y1_d = r_q;
		end else if (r_q >= POS_W'(4)) begin
			y1_d = y0_d;
		end else begin
			y_ok = 1'b0;
		end
	end

	// tap address: clamp position, find store row
	logic [POS_W-1:0] cx, ry, d_row;
	logic [3:0] d4, slot;
	logic [AW-1:0] raddr, waddr;
	always_comb begin
		if (cmd.fin) begin
			cx = x_q;
			ry = y_q;
		end else begin
			priority if (xpos_q < 0)
				cx = '0;
			else if (xpos_q > $signed({2'b00, w_m1}))
				cx = w_m1;
			else
				cx = POS_W'(xpos_q);
			priority if (ypos_q < 0)
				ry = '0;
			else if (ypos_q > $signed({2'b00, h_m1}))
				ry = h_m1;
			else
				ry = POS_W'(ypos_q);
		end
		d_row = r_q - ry;
		d4 = d_row[3:0];
		slot = (rs_q >= d4) ? rs_q - d4 : rs_q + 4'd9 - d4;
		raddr = AW'(AW'(slot) * ROW_STRIDE) + AW'(cx);
		waddr = AW'(AW'(rs_q) * ROW_STRIDE) + AW'(c_q);
	end

	// line store
	always_ff @(posedge clk) begin
		if (cmd.wr)
			mem[waddr] <= pix_q;
		if (cmd.rd || cmd.fin)
			rdata_q <= mem[raddr];
	end

	// final sharpen step
	logic [PIX_W-1:0] detail;
	logic [PIX_W:0] osum;
	always_comb begin
		detail = (rdata_q > blur_q) ? rdata_q - blur_q : '0;
		osum = {1'b0, rdata_q} + {1'b0, detail};
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= pixel_in;
			c_q <= (SPOS_W'(col_count_q) < w_s) ? col_count_q : w_m1;
			r_q <= (SPOS_W'(row_count_q) < h_s) ? row_count_q : h_m1;
		end
		if (cmd.mod)
			rs_q <= mod9(r_q);
		if (cmd.wr) begin
			x0_q <= x0_d;
			x1_q <= x1_d;
			y1_q <= y1_d;
			x_q <= x0_d;
			y_q <= y0_d;
		end
		if (cmd.pix_init) begin
			k_q <= '0;
			xpos_q <= $signed(SPOS_W'(x_q)) - SPOS_W'(4);
			hacc_q <= '0;
		end
		if (cmd.col_init) begin
			j_q <= '0;
			ypos_q <= $signed(SPOS_W'(y_q)) - SPOS_W'(4);
			vacc_q <= '0;
		end
		if (cmd.mul)
			prod_s1 <= PROD_W'(tap_weight(coef, j_q)) * PROD_W'(rdata_q);
		if (cmd.vacc) begin
			vacc_q <= vacc_q + ACC_W'(prod_s1);
			j_q <= j_q + TAP_W'(1);
			ypos_q <= ypos_q + SPOS_W'(1);
		end
		if (cmd.vrnd)
			vr_q <= round_sat(vacc_q);
		if (cmd.hmul)
			prod_s1 <= PROD_W'(tap_weight(coef, k_q)) * PROD_W'(vr_q);
		if (cmd.hacc) begin
			hacc_q <= hacc_q + ACC_W'(prod_s1);
			k_q <= k_q + TAP_W'(1);
			xpos_q <= xpos_q + SPOS_W'(1);
		end
		if (cmd.fin)
			blur_q <= round_sat(hacc_q);
		if (cmd.emit) begin
			pixel_out_q <= osum[PIX_W] ? '1 : osum[PIX_W-1:0];
			out_col_q <= x_q;
			out_row_q <= y_q;
			run_last_q <= sts.pix_last;
		end
		if (cmd.step) begin
			if (x_q == x1_q) begin
				x_q <= x0_q;
				y_q <= y_q + POS_W'(1);
			end else begin
				x_q <= x_q + POS_W'(1);
			end
		end
	end

	// position counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.adv) begin
				if (c_q == w_m1) begin
					col_count_q <= '0;
					row_count_q <= (r_q == h_m1) ? '0 : r_q + POS_W'(1);
				end else begin
					col_count_q <= c_q + POS_W'(1);
					row_count_q <= r_q;
				end
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (cmd.step)
				out_valid_q <= 1'b0;
		end
	end

	// status to controller
	always_comb begin
		sts.has_out = x_ok && y_ok;
		sts.j_last = (j_q == TAP_W'(NTAP - 1));
		sts.k_last = (k_q == TAP_W'(NTAP - 1));
		sts.pix_last = (x_q == x1_q) && (y_q == y1_q);
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign out_col = out_col_q;
	assign out_row = out_row_q;
	assign run_last = run_last_q;

endmodule

// File: rtl/unsharp_mask_gaussian_9x9.sv
// Unsharp-mask sharpener with a separable 9x9 Gaussian blur, one pixel per request.
// Input channel: in_valid / in_stall with pixel_in, pixels in raster order, Q0.16.
// Output channel: out_valid / out_stall with pixel_out, out_col, out_row and
// run_last; run_last marks the final result caused by one input request.
// Coefficients and frame size sit on the APB port at 4*index; write them only
// while the block is idle.
// One request at a time: a request that completes no output passes through the
// MOD, WR and ADV states; each output walks 9 columns of 9 taps, each tap read,
// multiplied and accumulated in turn, using one product register and the one
// read port of the line store; a frame corner completes up to 25 outputs.
// The receiver may stall: the output register holds its result and the block
// does not accept new input until all results of the current request are taken.
// Reset clears the position counters and restores the default coefficients
// and frame size; the line store is not cleared and needs no clearing pass.
module unsharp_mask_gaussian_9x9
	import usm_pkg::*;
#(
	parameter int MAX_WIDTH = 1920,
	parameter int MAX_HEIGHT = 1080
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PIX_W-1:0]  pixel_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  pixel_out,
	output logic [POS_W-1:0]  out_col,
	output logic [POS_W-1:0]  out_row,
	output logic              run_last
);

	coef_arr_t coef_q;
	logic [POS_W-1:0] frame_width_q, frame_height_q;
	logic [2:0] reg_idx;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= RST_COEF_CENTER;
			coef_q[1] <= RST_COEF_ONE;
			coef_q[2] <= RST_COEF_TWO;
			coef_q[3] <= RST_COEF_THREE;
			coef_q[4] <= RST_COEF_FOUR;
			frame_width_q <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_COEF_CENTER: coef_q[0] <= pwdata[15:0];
				REG_COEF_ONE: coef_q[1] <= pwdata[15:0];
				REG_COEF_TWO: coef_q[2] <= pwdata[15:0];
				REG_COEF_THREE: coef_q[3] <= pwdata[15:0];
				REG_COEF_FOUR: coef_q[4] <= pwdata[15:0];
				REG_FRAME_WIDTH: frame_width_q <= pwdata[10:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (reg_idx)
			REG_COEF_CENTER: prdata = 32'(coef_q[0]);
			REG_COEF_ONE: prdata = 32'(coef_q[1]);
			REG_COEF_TWO: prdata = 32'(coef_q[2]);
			REG_COEF_THREE: prdata = 32'(coef_q[3]);
			REG_COEF_FOUR: prdata = 32'(coef_q[4]);
			REG_FRAME_WIDTH: prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			default: prdata = '0;
		endcase
	end

	// controller
	usm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.out_stall(out_stall),
		.sts(sts),
		.in_stall(in_stall),
		.cmd(cmd)
	);

	// datapath
	usm_dp #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.coef(coef_q),
		.frame_width(frame_width_q),
		.frame_height(frame_height_q),
		.pixel_in(pixel_in),
		.out_valid(out_valid),
		.pixel_out(pixel_out),
		.out_col(out_col),
		.out_row(out_row),
		.run_last(run_last)
	);

`ifndef NO_ASSERTIONS
	// no new request while a result is pending
	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while output pending");

	// an accepted request blocks the input next cycle
	a_stall_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after request");

	// a taken result is not shown twice
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid)
		else $error("output repeated");
`endif

endmodule

// File: tb/testbench.sv
module testbench
	import usm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXW = 1920;
	localparam int MAXH = 1080;
	localparam int NREG = 7;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic last;
	} sharp_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic [PIX_W-1:0] pixel_in;
	logic out_valid;
	logic out_stall;
	logic [PIX_W-1:0] pixel_out;
	logic [POS_W-1:0] out_col;
	logic [POS_W-1:0] out_row;
	logic run_last;

	// predictor state
	logic [PIX_W-1:0] rows_mem [0:8][0:MAXW-1];
	int unsigned next_col;
	int unsigned next_row;
	logic [15:0] reg_val [0:NREG-1];

	logic [PIX_W-1:0] pixel_queue [$];
	sharp_t sharp_queue [$];
	int unsigned n_driven;
	int unsigned n_taken;
	int burst_left;
	int gap_left;
	int stall_mode;
	int stall_left;
	int fails;
	int total_items;

	unsharp_mask_gaussian_9x9 dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_in(pixel_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_out(pixel_out),
		.out_col(out_col),
		.out_row(out_row),
		.run_last(run_last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// timeout
	initial begin
		#40ms;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [PIX_W-1:0] round_clip(input logic [63:0] acc);
		logic [63:0] r;
		r = (acc + 64'd32768) >> 16;
		return (r > 64'd65535) ? 16'hFFFF : r[15:0];
	endfunction

	function automatic logic [63:0] weight_of(input int k);
		int d;
		d = (k < 4) ? 4 - k : k - 4;
		return 64'(reg_val[d]);
	endfunction

	function automatic int clip_idx(input int v, input int hi);
		return (v < 0) ? 0 : ((v > hi) ? hi : v);
	endfunction

	// blur, then boost the positive detail
	function automatic logic [PIX_W-1:0] sharpen(input int x, input int y, input int w,
			input int h);
		int slot [0:8];
		logic [63:0] hsum;
		logic [63:0] vsum;
		int cx;
		int p;
		int blur;
		int o;
		hsum = 0;
		for (int j = 0; j < 9; j++)
			slot[j] = clip_idx(y + j - 4, h - 1) % 9;
		for (int k = 0; k < 9; k++) begin
			cx = clip_idx(x + k - 4, w - 1);
			vsum = 0;
			for (int j = 0; j < 9; j++)
				vsum += weight_of(j) * 64'(rows_mem[slot[j]][cx]);
			hsum += weight_of(k) * 64'(round_clip(vsum));
		end
		blur = round_clip(hsum);
		p = rows_mem[y % 9][x];
		o = (p > blur) ? 2 * p - blur : p;
		return (o > 65535) ? 16'hFFFF : 16'(o);
	endfunction

	// store one pixel and queue the outputs it completes
	task automatic predict_pixel(input logic [PIX_W-1:0] p);
		int w;
		int h;
		int c;
		int r;
		int x0;
		int x1;
		int y0;
		int y1;
		sharp_t s;
		w = reg_val[REG_FRAME_WIDTH];
		h = reg_val[REG_FRAME_HEIGHT];
		w = (w < 9) ? 9 : ((w > MAXW) ? MAXW : w);
		h = (h < 9) ? 9 : ((h > MAXH) ? MAXH : h);
		c = (next_col < w) ? next_col : w - 1;
		r = (next_row < h) ? next_row : h - 1;
		rows_mem[r % 9][c] = p;
		if (c == w - 1) begin
			x0 = c - 4;
			x1 = c;
		end else begin
			x0 = c - 4;
			x1 = c - 4;
		end
		if (r == h - 1) begin
			y0 = r - 4;
			y1 = r;
		end else begin
			y0 = r - 4;
			y1 = r - 4;
		end
		if (x0 >= 0 && y0 >= 0) begin
			for (int y = y0; y <= y1; y++)
				for (int x = x0; x <= x1; x++) begin
					s.pix = sharpen(x, y, w, h);
					s.col = POS_W'(x);
					s.row = POS_W'(y);
					s.last = (x == x1 && y == y1);
					sharp_queue.push_back(s);
				end
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		next_col = c;
		next_row = r;
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	// pixel driver, bursts with gaps
	always @(negedge clk) begin
		if (arst_n && (!in_valid || n_taken == n_driven)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pixel_queue.size() > 0) begin
				pixel_in <= pixel_queue.pop_front();
				in_valid <= 1'b1;
				n_driven++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_left <= 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(50, 2000);
		end
		stall_left--;
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= $urandom_range(0, 1);
			end
			default: begin
				out_stall <= ($urandom_range(0, 7) != 0);
			end
		endcase
	end

	// accepted requests feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			n_taken++;
			predict_pixel(pixel_in);
		end
	end

	// compare outputs against predictions
	always @(posedge clk) begin
		sharp_t s;
		if (arst_n && out_valid && !out_stall) begin
			if (sharp_queue.size() == 0) begin
				report("unexpected output col", out_col, 0);
			end else begin
				s = sharp_queue.pop_front();
				if (out_col !== s.col)
					report("out_col", out_col, s.col);
				if (out_row !== s.row)
					report("out_row", out_row, s.row);
				if (pixel_out !== s.pix)
					report("pixel_out", pixel_out, s.pix);
				if (run_last !== s.last)
					report("run_last", run_last, s.last);
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input int unsigned value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		reg_val[idx] = (idx >= REG_FRAME_WIDTH) ? 16'(value & 32'h7FF) : 16'(value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pixel_queue.size() > 0 || n_taken != n_driven || sharp_queue.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_coefs(input int unsigned c0, input int unsigned c1,
			input int unsigned c2, input int unsigned c3, input int unsigned c4);
		reg_write(REG_COEF_CENTER, c0);
		reg_write(REG_COEF_ONE, c1);
		reg_write(REG_COEF_TWO, c2);
		reg_write(REG_COEF_THREE, c3);
		reg_write(REG_COEF_FOUR, c4);
	endtask

	// one whole frame of random pixels, with a share of extremes
	task automatic queue_frame(input int w, input int h);
		int sel;
		for (int i = 0; i < w * h; i++) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				pixel_queue.push_back(16'h0000);
			else if (sel == 1)
				pixel_queue.push_back(16'hFFFF);
			else
				pixel_queue.push_back(16'($urandom));
		end
		total_items += w * h;
	endtask

	initial begin
		int w;
		int h;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		pixel_in = '0;
		out_stall = 1'b0;
		n_driven = 0;
		n_taken = 0;
		burst_left = 0;
		gap_left = 0;
		stall_mode = 0;
		stall_left = 0;
		fails = 0;
		total_items = 0;
		next_col = 0;
		next_row = 0;
		reg_val[REG_COEF_CENTER] = RST_COEF_CENTER;
		reg_val[REG_COEF_ONE] = RST_COEF_ONE;
		reg_val[REG_COEF_TWO] = RST_COEF_TWO;
		reg_val[REG_COEF_THREE] = RST_COEF_THREE;
		reg_val[REG_COEF_FOUR] = RST_COEF_FOUR;
		reg_val[REG_FRAME_WIDTH] = RST_FRAME_WIDTH;
		reg_val[REG_FRAME_HEIGHT] = RST_FRAME_HEIGHT;
		for (int r = 0; r < 9; r++)
			for (int c = 0; c < MAXW; c++)
				rows_mem[r][c] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// out-of-range sizes saturate; settle on a 9x9 frame, default weights
		reg_write(REG_FRAME_WIDTH, 2047);
		reg_write(REG_FRAME_HEIGHT, 0);
		reg_write(REG_FRAME_WIDTH, 9);
		for (int i = 0; i < 81; i++) begin
			if (i % 9 == 4 || i / 9 == 4)
				pixel_queue.push_back(16'hFFFF);
			else if (i % 2 == 0)
				pixel_queue.push_back(16'h0000);
			else
				pixel_queue.push_back(16'($urandom));
		end
		total_items += 81;
		wait_idle();

		// full-scale weights drive both passes into saturation
		set_coefs(65535, 65535, 65535, 65535, 65535);
		reg_write(REG_FRAME_WIDTH, 10);
		reg_write(REG_FRAME_HEIGHT, 9);
		queue_frame(10, 9);
		wait_idle();

		// zero weights, widest and smallest size codes in passing
		set_coefs(0, 0, 0, 0, 0);
		reg_write(REG_FRAME_WIDTH, 1920);
		reg_write(REG_FRAME_HEIGHT, 1080);
		reg_write(REG_FRAME_WIDTH, 0);
		reg_write(REG_FRAME_HEIGHT, 12);
		queue_frame(9, 12);
		wait_idle();

		// random or default weights and small frame sizes
		while (total_items < 320) begin
			if ($urandom_range(0, 3) == 0)
				set_coefs(RST_COEF_CENTER, RST_COEF_ONE, RST_COEF_TWO, RST_COEF_THREE,
					RST_COEF_FOUR);
			else
				set_coefs($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 30000), $urandom_range(0, 20000),
					$urandom_range(0, 10000));
			w = $urandom_range(9, 16);
			h = $urandom_range(9, 12);
			reg_write(REG_FRAME_WIDTH, w);
			reg_write(REG_FRAME_HEIGHT, h);
			queue_frame(w, h);
			wait_idle();
		end

		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/usm_pkg.sv
rtl/usm_ctrl.sv
rtl/usm_dp.sv
rtl/unsharp_mask_gaussian_9x9.sv
tb/testbench.sv
